// File: rtl/g2r_pkg.sv
// ----------------------------------------------------------------------------
// g2r_pkg
// Shared types and character codes for the glob to regex transcoder.
// ----------------------------------------------------------------------------
package g2r_pkg;

  // Pattern scanner mode
  typedef enum logic [1:0] {
    MODE_NORMAL      = 2'd0,
    MODE_BRACKET     = 2'd1,
    MODE_ESCAPE      = 2'd2,
    MODE_ESC_BRACKET = 2'd3
  } mode_t;

  // Input kind flag
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Expansion entry: up to three output bytes for one input transaction
  localparam int unsigned EXP_MAX = 3;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  typedef struct packed {
    logic [EXP_MAX-1:0][7:0] bytes;
    logic [1:0]              cnt;   // 1 to 3 bytes held
    logic                    done;  // last byte is the closing anchor
  } exp_t;

  // Character codes
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Regex metacharacters that need a backslash outside brackets
  function automatic logic is_meta(input logic [7:0] c);
    is_meta = c inside {CH_PIPE, CH_DOT, CH_QMARK, CH_PLUS, CH_STAR, CH_CARET,
                        CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                        CH_LBRACE, CH_RBRACE, CH_BSLASH};
  endfunction

endpackage

// File: rtl/g2r_front.sv
// ----------------------------------------------------------------------------
// g2r_front
// Accepts pattern bytes, tracks scanner state and builds the expansion entry.
// ----------------------------------------------------------------------------
module g2r_front
  import g2r_pkg::*;
#(
  parameter int unsigned BRACE_DEPTH_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] char_in,
  input  logic       q_full,
  output logic       push,
  output exp_t       push_entry
);

  mode_t                       mode, mode_next;
  logic [BRACE_DEPTH_BITS-1:0] brace_depth, brace_depth_next;
  logic [1:0]                  bracket_offset, bracket_offset_next;
  logic                        at_pattern_start, at_pattern_start_next;

  logic                        accept;
  logic [1:0]                  off;
  logic                        depth_full, depth_zero;
  logic [EXP_MAX-1:0][7:0]     body;
  logic [1:0]                  body_cnt;
  logic [2:0]                  total;

  assign in_ready   = ~q_full;
  assign accept     = in_valid & in_ready;
  assign off        = (bracket_offset < 2'd2) ? bracket_offset + 2'd1 : 2'd2;
  assign depth_full = &brace_depth;
  assign depth_zero = ~|brace_depth;

  // Next scanner state
  always_comb begin
    mode_next             = mode;
    brace_depth_next      = brace_depth;
    bracket_offset_next   = bracket_offset;
    at_pattern_start_next = 1'b0;
    if (kind == KIND_END) begin
      mode_next             = MODE_NORMAL;
      brace_depth_next      = '0;
      bracket_offset_next   = 2'd0;
      at_pattern_start_next = 1'b1;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          case (char_in)
            CH_BSLASH: mode_next = MODE_ESCAPE;
            CH_LBRACE: begin
              if (!depth_full) brace_depth_next = brace_depth + BRACE_DEPTH_BITS'(1);
            end
            CH_RBRACE: begin
              if (!depth_zero) brace_depth_next = brace_depth - BRACE_DEPTH_BITS'(1);
            end
            CH_LBRACK: begin
              mode_next           = MODE_BRACKET;
              bracket_offset_next = 2'd0;
            end
            default: ;
          endcase
        end
        MODE_BRACKET: begin
          bracket_offset_next = off;
          if (char_in == CH_BSLASH) mode_next = MODE_ESC_BRACKET;
          else if (char_in == CH_RBRACK && off > 2'd1) mode_next = MODE_NORMAL;
        end
        MODE_ESCAPE: mode_next = MODE_NORMAL;
        default: begin
          bracket_offset_next = off;
          mode_next           = MODE_BRACKET;
        end
      endcase
    end
  end

  // Bytes caused by the current byte, before the start anchor
  always_comb begin
    body     = '0;
    body_cnt = 2'd0;
    if (kind == KIND_END) begin
      body[0]  = CH_DOLLAR;
      body_cnt = 2'd1;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          case (char_in)
            CH_BSLASH: body_cnt = 2'd0;
            CH_STAR: begin
              body[0] = CH_DOT; body[1] = CH_STAR; body_cnt = 2'd2;
            end
            CH_QMARK: begin
              body[0] = CH_DOT; body_cnt = 2'd1;
            end
            CH_LBRACE: begin
              body[0] = CH_LPAREN; body[1] = CH_LPAREN; body_cnt = 2'd2;
            end
            CH_COMMA: begin
              if (!depth_zero) begin
                body[0] = CH_RPAREN; body[1] = CH_PIPE; body[2] = CH_LPAREN;
                body_cnt = 2'd3;
              end else begin
                body[0] = CH_COMMA; body_cnt = 2'd1;
              end
            end
            CH_RBRACE: begin
              if (!depth_zero) begin
                body[0] = CH_RPAREN; body[1] = CH_RPAREN;
              end else begin
                body[0] = CH_BSLASH; body[1] = CH_RBRACE;
              end
              body_cnt = 2'd2;
            end
            CH_LBRACK: begin
              body[0] = CH_LBRACK; body_cnt = 2'd1;
            end
            default: begin
              if (is_meta(char_in)) begin
                body[0] = CH_BSLASH; body[1] = char_in; body_cnt = 2'd2;
              end else begin
                body[0] = char_in; body_cnt = 2'd1;
              end
            end
          endcase
        end
        MODE_BRACKET: begin
          if (char_in == CH_BSLASH) begin
            body_cnt = 2'd0;
          end else if (char_in == CH_BANG) begin
            body[0]  = (off == 2'd1) ? CH_CARET : CH_BANG;
            body_cnt = 2'd1;
          end else begin
            body[0]  = char_in;
            body_cnt = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          if (is_meta(char_in)) begin
            body[0] = CH_BSLASH; body[1] = char_in; body_cnt = 2'd2;
          end else begin
            body[0] = char_in; body_cnt = 2'd1;
          end
        end
        default: begin
          body[0]  = char_in;
          body_cnt = 2'd1;
        end
      endcase
    end
  end

  // Prepend the start anchor and saturate at three bytes
  always_comb begin
    total = {1'b0, body_cnt} + {2'b00, at_pattern_start};
    push_entry.done = (kind == KIND_END);
    if (at_pattern_start) begin
      push_entry.bytes[0] = CH_CARET;
      push_entry.bytes[1] = body[0];
      push_entry.bytes[2] = body[1];
    end else begin
      push_entry.bytes = body;
    end
    push_entry.cnt = (total > 3'd3) ? 2'd3 : total[1:0];
    push = accept & (total != 3'd0);
  end

  // Update state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_NORMAL;
      brace_depth      <= '0;
      bracket_offset   <= 2'd0;
      at_pattern_start <= 1'b1;
    end else if (accept) begin
      mode             <= mode_next;
      brace_depth      <= brace_depth_next;
      bracket_offset   <= bracket_offset_next;
      at_pattern_start <= at_pattern_start_next;
    end
  end

endmodule

// File: rtl/g2r_queue.sv
// ----------------------------------------------------------------------------
// g2r_queue
// Short queue of expansion entries between the front and back parts.
// ----------------------------------------------------------------------------
module g2r_queue
  import g2r_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  exp_t push_entry,
  input  logic pop,
  output exp_t head,
  output logic empty,
  output logic full
);

  exp_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign head  = mem[rd_ptr];

  // Write entries
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == (QPTR_W)'(QDEPTH-1)) ? '0 : wr_ptr + (QPTR_W)'(1);
      if (pop)  rd_ptr <= (rd_ptr == (QPTR_W)'(QDEPTH-1)) ? '0 : rd_ptr + (QPTR_W)'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/g2r_back.sv
// ----------------------------------------------------------------------------
// g2r_back
// Holds one expansion entry and sends its bytes one transaction at a time.
// ----------------------------------------------------------------------------
module g2r_back
  import g2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  exp_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out,
  output logic       run_last,
  output logic       pattern_done
);

  exp_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       xfer;

  assign out_valid    = cur_valid;
  assign char_out     = cur.bytes[idx];
  assign run_last     = (idx == cur.cnt - 2'd1);
  assign pattern_done = run_last & cur.done;
  assign xfer         = cur_valid & out_ready;
  assign pop          = ~empty & (~cur_valid | (xfer & run_last));

  // Load the next entry once the current one is drained
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (xfer) begin
      if (run_last) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: rtl/glob_to_regex_transcoder_top.sv
// ----------------------------------------------------------------------------
// glob_to_regex_transcoder_top
// Translates a shell glob, byte by byte, into an anchored POSIX regex.
//
//   channel   dir  tdata             tuser          tlast
//   s_axis    in   char_in[7:0]      kind           -
//   m_axis    out  char_out[7:0]     pattern_done   run_last
//
// Each input transaction is classified combinationally and queued as 0 to 3
// bytes; while m_axis_tready is high the output side sends one byte per
// cycle, and single-byte items flow at one per cycle. A two-entry queue
// decouples the sides: input stalls only when it is full. Reset is
// synchronous and clears the scanner state, queue and output stage; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module glob_to_regex_transcoder_top
  import g2r_pkg::*;
#(
  parameter int unsigned BRACE_DEPTH_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tuser,   // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_out
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] pattern_done
);

  logic push, pop, q_empty, q_full;
  exp_t push_entry, head;

  // Classify incoming bytes
  g2r_front #(
    .BRACE_DEPTH_BITS(BRACE_DEPTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .kind      (s_axis_tuser),
    .char_in   (s_axis_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  // Buffer expansion entries
  g2r_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Serialise bytes to the output
  g2r_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .char_out    (m_axis_tdata),
    .run_last    (m_axis_tlast),
    .pattern_done(m_axis_tuser)
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glob to regex transcoder.
//
// Glob patterns go in on the slave stream one byte per transaction, each
// closed by an end marker. A behavioural translator in the bench predicts
// the regex bytes for every accepted transaction. The monitor compares each
// output transaction, field by field, with the oldest prediction.
//
// Stimulus runs in two parts. A directed table covers the anchors, the
// extremes of the byte range, every glob operator and the escape, bracket
// and end-of-pattern corner cases. Random patterns follow: mostly
// well-formed globs, brace nesting near and past the counter limit, and some
// noise. The sender idles in bursts. The receiver stalls on its own pattern
// and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb
  import g2r_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Keep the brace counter narrow so that nesting can reach its limit
  localparam int unsigned DEPTH_BITS      = 4;
  localparam int unsigned RANDOM_ITEMS    = 280;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned NUM_SPECIALS    = 16;

  localparam logic [7:0] GLOB_SPECIALS [NUM_SPECIALS] = '{
    CH_STAR, CH_QMARK, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_LBRACK, CH_RBRACK,
    CH_BANG, CH_BSLASH, CH_DOT, CH_PLUS, CH_CARET, CH_DOLLAR, CH_LPAREN,
    CH_RPAREN, CH_PIPE
  };

  // One predicted output transaction
  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       pattern_done;
  } regex_byte_t;

  // One row of the directed table; bytes are listed from index 2 down to index 0
  typedef struct packed {
    logic            kind;
    logic [7:0]      ch;
    logic            typed;
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
  } glob_row_t;

  localparam int unsigned NUM_ROWS = 26;
  localparam glob_row_t DIRECTED [NUM_ROWS] = '{
    // end marker straight after reset gives an empty anchored regex
    '{KIND_END,  8'h00,     1'b1, 2'd2, {8'h00, CH_DOLLAR, CH_CARET}},
    '{KIND_CHAR, 8'h61,     1'b1, 2'd2, {8'h00, 8'h61, CH_CARET}},
    '{KIND_CHAR, 8'h00,     1'b1, 2'd1, {16'h0000, 8'h00}},
    '{KIND_CHAR, 8'hFF,     1'b1, 2'd1, {16'h0000, 8'hFF}},
    '{KIND_CHAR, CH_STAR,   1'b1, 2'd2, {8'h00, CH_STAR, CH_DOT}},
    '{KIND_CHAR, CH_QMARK,  1'b1, 2'd1, {16'h0000, CH_DOT}},
    '{KIND_CHAR, CH_LBRACE, 1'b1, 2'd2, {8'h00, CH_LPAREN, CH_LPAREN}},
    '{KIND_CHAR, CH_COMMA,  1'b1, 2'd3, {CH_LPAREN, CH_PIPE, CH_RPAREN}},
    '{KIND_CHAR, CH_RBRACE, 1'b1, 2'd2, {8'h00, CH_RPAREN, CH_RPAREN}},
    // comma and closing brace with no group open
    '{KIND_CHAR, CH_COMMA,  1'b1, 2'd1, {16'h0000, CH_COMMA}},
    '{KIND_CHAR, CH_RBRACE, 1'b1, 2'd2, {8'h00, CH_RBRACE, CH_BSLASH}},
    '{KIND_CHAR, CH_PLUS,   1'b1, 2'd2, {8'h00, CH_PLUS, CH_BSLASH}},
    '{KIND_CHAR, CH_BSLASH, 1'b1, 2'd0, 24'h0},
    '{KIND_CHAR, CH_DOLLAR, 1'b1, 2'd2, {8'h00, CH_DOLLAR, CH_BSLASH}},
    // bang straight after the opening bracket becomes a caret
    '{KIND_CHAR, CH_LBRACK, 1'b1, 2'd1, {16'h0000, CH_LBRACK}},
    '{KIND_CHAR, CH_BANG,   1'b1, 2'd1, {16'h0000, CH_CARET}},
    '{KIND_CHAR, CH_RBRACK, 1'b0, 2'd0, 24'h0},
    // leading ']' is literal, later bang is literal, escaped ']' stays open
    '{KIND_CHAR, CH_LBRACK, 1'b0, 2'd0, 24'h0},
    '{KIND_CHAR, CH_RBRACK, 1'b0, 2'd0, 24'h0},
    '{KIND_CHAR, CH_BANG,   1'b0, 2'd0, 24'h0},
    '{KIND_CHAR, CH_BSLASH, 1'b0, 2'd0, 24'h0},
    '{KIND_CHAR, CH_RBRACK, 1'b0, 2'd0, 24'h0},
    '{KIND_CHAR, CH_RBRACK, 1'b0, 2'd0, 24'h0},
    // end marker with a bracket open, char field ignored
    '{KIND_CHAR, CH_LBRACK, 1'b0, 2'd0, 24'h0},
    '{KIND_END,  8'hFF,     1'b0, 2'd0, 24'h0},
    // leading backslash still yields the start anchor
    '{KIND_CHAR, CH_BSLASH, 1'b0, 2'd0, 24'h0}
  };

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] char_in
  logic       s_axis_tuser;   // [0] kind
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] char_out
  logic       m_axis_tlast;   // run_last
  logic       m_axis_tuser;   // [0] pattern_done

  // Translator state, mirrored from the scanner
  mode_t                 glob_mode;
  logic [DEPTH_BITS-1:0] open_braces;
  logic [1:0]            bracket_pos;
  logic                  pattern_fresh;

  regex_byte_t regex_q [$];
  regex_byte_t want_byte;
  logic [7:0]  glob_text [$];
  int          burst_left;
  int          err_count;
  int          items_sent;
  int          cycle_cnt;
  bit          hold_off_req;
  bit          paused;

  glob_to_regex_transcoder_top #(
    .BRACE_DEPTH_BITS(DEPTH_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Bytes that a backslash must protect outside brackets
  function automatic logic regex_special(input logic [7:0] c);
    case (c)
      CH_PIPE, CH_DOT, CH_QMARK, CH_PLUS, CH_STAR, CH_CARET, CH_DOLLAR,
      CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
      CH_BSLASH: regex_special = 1'b1;
      default:   regex_special = 1'b0;
    endcase
  endfunction

  // Append one byte to the pattern being built
  function automatic void append_glob(input logic [7:0] c);
    glob_text = {glob_text, c};
  endfunction

  task automatic clear_translator();
    glob_mode     = MODE_NORMAL;
    open_braces   = '0;
    bracket_pos   = 2'd0;
    pattern_fresh = 1'b1;
  endtask

  // Translate one glob transaction into 0 to 3 regex bytes
  task automatic translate_glob_byte(input logic k, input logic [7:0] c,
                                     output int n, output logic [2:0][7:0] b);
    n = 0;
    b = '0;
    if (pattern_fresh) begin
      b[n] = CH_CARET;
      n++;
      pattern_fresh = 1'b0;
    end
    if (k == KIND_END) begin
      b[n] = CH_DOLLAR;
      n++;
      clear_translator();
    end else begin
      case (glob_mode)
        MODE_NORMAL: begin
          case (c)
            CH_BSLASH: glob_mode = MODE_ESCAPE;
            CH_STAR: begin
              b[n] = CH_DOT;
              b[n+1] = CH_STAR;
              n += 2;
            end
            CH_QMARK: begin
              b[n] = CH_DOT;
              n++;
            end
            CH_LBRACE: begin
              // saturate: still open the group, just stop counting
              if (open_braces != '1) open_braces++;
              b[n] = CH_LPAREN;
              b[n+1] = CH_LPAREN;
              n += 2;
            end
            CH_COMMA: begin
              if (open_braces != '0) begin
                b[n] = CH_RPAREN;
                b[n+1] = CH_PIPE;
                b[n+2] = CH_LPAREN;
                n += 3;
              end else begin
                b[n] = CH_COMMA;
                n++;
              end
            end
            CH_RBRACE: begin
              if (open_braces != '0) begin
                open_braces--;
                b[n] = CH_RPAREN;
                b[n+1] = CH_RPAREN;
              end else begin
                b[n] = CH_BSLASH;
                b[n+1] = CH_RBRACE;
              end
              n += 2;
            end
            CH_LBRACK: begin
              glob_mode   = MODE_BRACKET;
              bracket_pos = 2'd0;
              b[n] = CH_LBRACK;
              n++;
            end
            default: begin
              if (regex_special(c)) begin
                b[n] = CH_BSLASH;
                n++;
              end
              b[n] = c;
              n++;
            end
          endcase
        end
        MODE_BRACKET: begin
          if (bracket_pos < 2'd2) bracket_pos++;
          if (c == CH_BSLASH) begin
            glob_mode = MODE_ESC_BRACKET;
          end else begin
            if (c == CH_BANG) begin
              b[n] = (bracket_pos == 2'd1) ? CH_CARET : CH_BANG;
            end else begin
              // ']' only closes once it is not the first member
              if (c == CH_RBRACK && bracket_pos > 2'd1) glob_mode = MODE_NORMAL;
              b[n] = c;
            end
            n++;
          end
        end
        MODE_ESCAPE: begin
          if (regex_special(c)) begin
            b[n] = CH_BSLASH;
            n++;
          end
          b[n] = c;
          n++;
          glob_mode = MODE_NORMAL;
        end
        default: begin
          if (bracket_pos < 2'd2) bracket_pos++;
          b[n] = c;
          n++;
          glob_mode = MODE_BRACKET;
        end
      endcase
    end
  endtask

  task automatic queue_expected(input int n, input logic [2:0][7:0] b,
                                input logic k);
    regex_byte_t e;
    for (int i = 0; i < n; i++) begin
      e.char_out     = b[i];
      e.run_last     = (i == n - 1);
      e.pattern_done = k && (i == n - 1);
      regex_q = {regex_q, e};
    end
  endtask

  // Offer one transaction in bursts with random gaps, then predict its bytes
  task automatic feed_glob_byte(input logic k, input logic [7:0] c,
                                input logic typed, input logic [1:0] nb,
                                input logic [2:0][7:0] typed_bytes);
    int              gap;
    int              n;
    logic [2:0][7:0] b;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= k;
    do @(posedge clk); while (!s_axis_tready);
    translate_glob_byte(k, c, n, b);
    if (typed) queue_expected(nb, typed_bytes, k);
    else queue_expected(n, b, k);
  endtask

  // Drop valid and hold until every predicted byte has come out
  task automatic drain_outputs();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (regex_q.size() == 0);
  endtask

  // Build one random glob: mostly well formed, some deep braces, some noise
  task automatic build_pattern();
    int shape;
    int alts;
    glob_text.delete();
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // nest from just below to past the counter limit, then unwind with commas and closes
      repeat ($urandom_range(14, 19)) append_glob(CH_LBRACE);
      repeat ($urandom_range(10, 22))
        append_glob(($urandom_range(0, 2) == 0) ? CH_COMMA : CH_RBRACE);
    end else if (shape <= 2) begin
      repeat ($urandom_range(0, 10))
        append_glob($urandom_range(0, 1) ?
                    GLOB_SPECIALS[$urandom_range(0, NUM_SPECIALS - 1)] :
                    8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 7)) begin
        case ($urandom_range(0, 7))
          0: append_glob(8'($urandom_range(8'h61, 8'h7A)));
          1: append_glob(8'($urandom_range(0, 255)));
          2: append_glob(CH_STAR);
          3: append_glob(CH_QMARK);
          4: begin
            append_glob(CH_BSLASH);
            append_glob($urandom_range(0, 1) ?
                        GLOB_SPECIALS[$urandom_range(0, NUM_SPECIALS - 1)] :
                        8'($urandom_range(0, 255)));
          end
          5: begin
            append_glob(CH_LBRACK);
            if ($urandom_range(0, 1)) append_glob(CH_BANG);
            if ($urandom_range(0, 3) == 0) append_glob(CH_RBRACK);
            repeat ($urandom_range(1, 3)) begin
              if ($urandom_range(0, 3) == 0) begin
                append_glob(CH_BSLASH);
                append_glob(8'($urandom_range(0, 255)));
              end else begin
                append_glob(8'($urandom_range(8'h21, 8'h7E)));
              end
            end
            append_glob(CH_RBRACK);
          end
          6: begin
            alts = $urandom_range(1, 3);
            append_glob(CH_LBRACE);
            for (int i = 0; i < alts; i++) begin
              if (i > 0) append_glob(CH_COMMA);
              append_glob($urandom_range(0, 3) == 0 ? CH_STAR :
                          8'($urandom_range(8'h61, 8'h7A)));
            end
            append_glob(CH_RBRACE);
          end
          default: append_glob(GLOB_SPECIALS[$urandom_range(9, NUM_SPECIALS - 1)]);
        endcase
      end
    end
  endtask

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (regex_q.size() == 0) begin
        $error("unexpected output transaction: char_out %02h", m_axis_tdata);
        err_count++;
      end else begin
        want_byte = regex_q.pop_front();
        if (m_axis_tdata !== want_byte.char_out) begin
          $error("char_out: expected %02h, got %02h", want_byte.char_out, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tlast !== want_byte.run_last) begin
          $error("run_last: expected %0b, got %0b", want_byte.run_last, m_axis_tlast);
          err_count++;
        end
        if (m_axis_tuser !== want_byte.pattern_done) begin
          $error("pattern_done: expected %0b, got %0b",
                 want_byte.pattern_done, m_axis_tuser);
          err_count++;
        end
      end
    end
  end

  // Receiver: stall on its own pattern, with one long hold-off on request
  initial begin : rx_side
    int style;
    int len;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      style = $urandom_range(0, 3);
      len   = $urandom_range(10, 60);
      for (int k = 0; k < len; k++) begin
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (k % 3 != 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Give up on a hung run
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus: reset, directed table, random patterns, drain
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = KIND_CHAR;
    err_count     = 0;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    paused        = 1'b0;
    items_sent    = 0;
    clear_translator();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      feed_glob_byte(DIRECTED[i].kind, DIRECTED[i].ch, DIRECTED[i].typed,
                     DIRECTED[i].nbytes, DIRECTED[i].bytes);
    drain_outputs();

    // Long receiver hold-off while the sender keeps offering
    hold_off_req = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      build_pattern();
      foreach (glob_text[j]) begin
        feed_glob_byte(KIND_CHAR, glob_text[j], 1'b0, 2'd0, '0);
        items_sent++;
      end
      feed_glob_byte(KIND_END, 8'($urandom_range(0, 255)), 1'b0, 2'd0, '0);
      items_sent++;
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_outputs();
      end
    end

    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
